// ===== src/prh_pkg.sv =====
// Shared types, codes and defaults for the preemptive priority ready heap.
package prh_pkg;

	// Default number of heap slots.
	localparam int unsigned HeapDepthDefault = 64;

	// Operation codes carried by the operation field.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// One heap slot.
	typedef struct packed {
		logic [15:0] pid;
		logic [15:0] burst;
		logic [7:0]  prio;
	} entry_t;

	// Source of the data written into the hole slot.
	typedef enum logic [2:0] {
		WR_NONE,
		WR_NEW,
		WR_PARENT,
		WR_PARENT_CUT,
		WR_LAST,
		WR_CHILD
	} wr_sel_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INS_READ,
		ST_INS_CMP,
		ST_INS_ROOT,
		ST_REM_READ,
		ST_REM_LOAD,
		ST_DN_CHECK,
		ST_DN_CMP,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		logic    set_status;
		status_t status;
		logic    set_disp;
		logic    ins_start;
		logic    rem_start;
		logic    rd_parent;
		logic    rd_last;
		logic    rd_children;
		logic    hold_last;
		wr_sel_t wr_sel;
		logic    hole_to_parent;
		logic    hole_to_best;
		logic    set_start;
		logic    load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_insert;
		logic full;
		logic empty;
		logic parent_is_root;
		logic new_lt_parent;
		logic no_left;
		logic best_is_child;
	} sts_t;

endpackage

// ===== src/preemptive_priority_ready_heap.sv =====
// Top level of the preemptive priority ready heap: controller plus datapath.
//
//   channel | direction | handshake            | payload
//   in      | to block  | in_valid / in_stall  | operation, current_time, process_id,
//           |           |                      | burst_time, priority_level
//   out     | from block| out_valid / out_stall| status, dispatched, running_*, entry_total,
//           |           |                      | removed_*
//
// One transaction at a time. Each heap level walked, at most log2(HEAP_DEPTH), takes a
// registered read of the heap memory followed by the compare and write. Full and empty
// rejects go straight to delivery without touching the heap. Reset clears the count,
// hole and start time and the controller state; the memory needs no clearing pass. A
// stalled result holds in the output register, and the next transaction is accepted and
// worked on meanwhile up to the point of delivery.
module preemptive_priority_ready_heap #(
	parameter int unsigned HEAP_DEPTH = prh_pkg::HeapDepthDefault,
	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          operation,
	input  logic [31:0]   current_time,
	input  logic [15:0]   process_id,
	input  logic [15:0]   burst_time,
	input  logic [7:0]    priority_level,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic          dispatched,
	output logic          running_valid,
	output logic [15:0]   running_pid,
	output logic [15:0]   running_remaining,
	output logic [31:0]   running_since,
	output logic [CW-1:0] entry_total,
	output logic [15:0]   removed_pid,
	output logic [15:0]   removed_burst,
	output logic [7:0]    removed_priority
);

	prh_pkg::cmd_t cmd;
	prh_pkg::sts_t sts;

	// Sequencer.
	prh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Heap storage and arithmetic.
	prh_dpath #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.operation         (operation),
		.current_time      (current_time),
		.process_id        (process_id),
		.burst_time        (burst_time),
		.priority_level    (priority_level),
		.status            (status),
		.dispatched        (dispatched),
		.running_valid     (running_valid),
		.running_pid       (running_pid),
		.running_remaining (running_remaining),
		.running_since     (running_since),
		.entry_total       (entry_total),
		.removed_pid       (removed_pid),
		.removed_burst     (removed_burst),
		.removed_priority  (removed_priority)
	);

endmodule

// ===== src/prh_ctrl.sv =====
// Controller state machine that sequences inserts, removes and sift steps.
module prh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  prh_pkg::sts_t  sts,
	output prh_pkg::cmd_t  cmd
);

	prh_pkg::state_t state_q;
	prh_pkg::state_t state_next;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != prh_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prh_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Output valid flag: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			prh_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = prh_pkg::ST_DECODE;
				end
			end
			prh_pkg::ST_DECODE: begin
				if (sts.is_insert) begin
					if (sts.full) begin
						cmd.set_status = 1'b1;
						cmd.status     = prh_pkg::STATUS_FULL;
						state_next     = prh_pkg::ST_FINISH;
					end else begin
						cmd.ins_start = 1'b1;
						state_next    = sts.empty ? prh_pkg::ST_INS_ROOT : prh_pkg::ST_INS_READ;
					end
				end else if (sts.empty) begin
					cmd.set_status = 1'b1;
					cmd.status     = prh_pkg::STATUS_EMPTY;
					state_next     = prh_pkg::ST_FINISH;
				end else begin
					cmd.rem_start = 1'b1;
					state_next    = prh_pkg::ST_REM_READ;
				end
			end
			prh_pkg::ST_INS_READ: begin
				cmd.rd_parent = 1'b1;
				state_next    = prh_pkg::ST_INS_CMP;
			end
			prh_pkg::ST_INS_CMP: begin
				if (!sts.new_lt_parent) begin
					cmd.wr_sel = prh_pkg::WR_NEW;
					state_next = prh_pkg::ST_FINISH;
				end else if (sts.parent_is_root) begin
					cmd.wr_sel         = prh_pkg::WR_PARENT_CUT;
					cmd.hole_to_parent = 1'b1;
					state_next         = prh_pkg::ST_INS_ROOT;
				end else begin
					cmd.wr_sel         = prh_pkg::WR_PARENT;
					cmd.hole_to_parent = 1'b1;
					state_next         = prh_pkg::ST_INS_READ;
				end
			end
			prh_pkg::ST_INS_ROOT: begin
				cmd.wr_sel    = prh_pkg::WR_NEW;
				cmd.set_start = 1'b1;
				cmd.set_disp  = 1'b1;
				state_next    = prh_pkg::ST_FINISH;
			end
			prh_pkg::ST_REM_READ: begin
				if (sts.empty) begin
					state_next = prh_pkg::ST_FINISH;
				end else begin
					cmd.rd_last = 1'b1;
					state_next  = prh_pkg::ST_REM_LOAD;
				end
			end
			prh_pkg::ST_REM_LOAD: begin
				cmd.hold_last = 1'b1;
				state_next    = prh_pkg::ST_DN_CHECK;
			end
			prh_pkg::ST_DN_CHECK: begin
				if (sts.no_left) begin
					cmd.wr_sel    = prh_pkg::WR_LAST;
					cmd.set_start = 1'b1;
					cmd.set_disp  = 1'b1;
					state_next    = prh_pkg::ST_FINISH;
				end else begin
					cmd.rd_children = 1'b1;
					state_next      = prh_pkg::ST_DN_CMP;
				end
			end
			prh_pkg::ST_DN_CMP: begin
				if (sts.best_is_child) begin
					cmd.wr_sel       = prh_pkg::WR_CHILD;
					cmd.hole_to_best = 1'b1;
					state_next       = prh_pkg::ST_DN_CHECK;
				end else begin
					cmd.wr_sel    = prh_pkg::WR_LAST;
					cmd.set_start = 1'b1;
					cmd.set_disp  = 1'b1;
					state_next    = prh_pkg::ST_FINISH;
				end
			end
			prh_pkg::ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_next   = prh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = prh_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/prh_dpath.sv =====
// Datapath: heap memory, hole and count registers, root copy and result register.
module prh_dpath #(
	parameter int unsigned HEAP_DEPTH = prh_pkg::HeapDepthDefault,
	localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1,
	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  prh_pkg::cmd_t          cmd,
	output prh_pkg::sts_t          sts,
	input  logic                   operation,
	input  logic [31:0]            current_time,
	input  logic [15:0]            process_id,
	input  logic [15:0]            burst_time,
	input  logic [7:0]             priority_level,
	output logic [1:0]             status,
	output logic                   dispatched,
	output logic                   running_valid,
	output logic [15:0]            running_pid,
	output logic [15:0]            running_remaining,
	output logic [31:0]            running_since,
	output logic [CW-1:0]          entry_total,
	output logic [15:0]            removed_pid,
	output logic [15:0]            removed_burst,
	output logic [7:0]             removed_priority
);

	localparam int unsigned IW = AW + 1;

	prh_pkg::entry_t heap_mem [HEAP_DEPTH];

	// Request registers.
	logic            req_op_q;
	logic [31:0]     req_time_q;
	prh_pkg::entry_t req_entry_q;

	// Heap bookkeeping.
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   hole_q;
	logic [31:0]     start_q;
	prh_pkg::entry_t root_q;
	prh_pkg::entry_t last_q;
	prh_pkg::entry_t removed_q;
	prh_pkg::entry_t rd0_q;
	prh_pkg::entry_t rd1_q;
	prh_pkg::status_t status_q;
	logic            disp_q;

	// Result register.
	logic [1:0]      out_status_q;
	logic            out_disp_q;
	logic            out_rvalid_q;
	logic [15:0]     out_rpid_q;
	logic [15:0]     out_rburst_q;
	logic [31:0]     out_since_q;
	logic [CW-1:0]   out_total_q;
	prh_pkg::entry_t out_removed_q;

	// Index arithmetic around the hole.
	logic [AW-1:0]   parent_idx;
	logic [IW-1:0]   l_idx;
	logic [IW-1:0]   r_idx;
	logic            r_ok;
	logic [AW-1:0]   rd_addr0;
	logic [AW-1:0]   rd_addr1;
	logic            rd_en;

	// Child selection and preemption charge.
	logic            left_lt;
	logic            right_lt;
	prh_pkg::entry_t best_data;
	logic [AW-1:0]   best_idx;
	logic [31:0]     ran;
	logic [15:0]     cut_burst;
	prh_pkg::entry_t cut_entry;
	prh_pkg::entry_t wr_data;
	logic            wr_en;

	assign parent_idx = (hole_q - AW'(1)) >> 1;
	assign l_idx      = {hole_q, 1'b1};
	assign r_idx      = l_idx + IW'(1);
	assign r_ok       = r_idx < IW'(count_q);

	assign rd_en    = cmd.rd_parent || cmd.rd_last || cmd.rd_children;
	assign rd_addr0 = cmd.rd_last ? count_q[AW-1:0] :
	                  (cmd.rd_children ? l_idx[AW-1:0] : parent_idx);
	assign rd_addr1 = r_ok ? r_idx[AW-1:0] : l_idx[AW-1:0];

	// Smaller child wins, left on ties, and only when strictly below the moving entry.
	assign left_lt   = rd0_q.prio < last_q.prio;
	assign right_lt  = r_ok && (rd1_q.prio < (left_lt ? rd0_q.prio : last_q.prio));
	assign best_data = right_lt ? rd1_q : rd0_q;
	assign best_idx  = right_lt ? r_idx[AW-1:0] : l_idx[AW-1:0];

	// The displaced root is charged the time it ran, saturating at zero.
	assign ran       = req_time_q - start_q;
	assign cut_burst = ((ran[31:16] != 16'd0) || (rd0_q.burst <= ran[15:0])) ? 16'd0 :
	                   rd0_q.burst - ran[15:0];
	always_comb begin
		cut_entry       = rd0_q;
		cut_entry.burst = cut_burst;
	end

	// Write data select.
	always_comb begin
		wr_en   = 1'b1;
		wr_data = req_entry_q;
		case (cmd.wr_sel)
			prh_pkg::WR_NEW:        wr_data = req_entry_q;
			prh_pkg::WR_PARENT:     wr_data = rd0_q;
			prh_pkg::WR_PARENT_CUT: wr_data = cut_entry;
			prh_pkg::WR_LAST:       wr_data = last_q;
			prh_pkg::WR_CHILD:      wr_data = best_data;
			default:                wr_en   = 1'b0;
		endcase
	end

	// Status to the controller.
	assign sts.is_insert      = (req_op_q == prh_pkg::OP_INSERT);
	assign sts.full           = (count_q == CW'(HEAP_DEPTH));
	assign sts.empty          = (count_q == '0);
	assign sts.parent_is_root = (parent_idx == '0);
	assign sts.new_lt_parent  = req_entry_q.prio < rd0_q.prio;
	assign sts.no_left        = l_idx >= IW'(count_q);
	assign sts.best_is_child  = left_lt || right_lt;

	// Heap memory: one write port at the hole, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[hole_q] <= wr_data;
		end
		if (rd_en) begin
			rd0_q <= heap_mem[rd_addr0];
			rd1_q <= heap_mem[rd_addr1];
		end
	end

	// Count, hole and root start time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hole_q  <= '0;
			start_q <= '0;
		end else begin
			if (cmd.ins_start) begin
				hole_q  <= count_q[AW-1:0];
				count_q <= count_q + CW'(1);
			end else if (cmd.rem_start) begin
				hole_q  <= '0;
				count_q <= count_q - CW'(1);
			end else if (cmd.hole_to_parent) begin
				hole_q <= parent_idx;
			end else if (cmd.hole_to_best) begin
				hole_q <= best_idx;
			end
			if (cmd.set_start) begin
				start_q <= req_time_q;
			end
		end
	end

	// Request capture, root copy and per-transaction flags.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_q          <= operation;
			req_time_q        <= current_time;
			req_entry_q.pid   <= process_id;
			req_entry_q.burst <= burst_time;
			req_entry_q.prio  <= priority_level;
			status_q          <= prh_pkg::STATUS_OK;
			disp_q            <= 1'b0;
			removed_q         <= '0;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.set_disp) begin
			disp_q <= 1'b1;
		end
		if (cmd.rem_start) begin
			removed_q <= root_q;
		end
		if (cmd.hold_last) begin
			last_q <= rd0_q;
		end
		if (wr_en && (hole_q == '0)) begin
			root_q <= wr_data;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q  <= status_q;
			out_disp_q    <= disp_q;
			out_rvalid_q  <= (count_q != '0);
			out_rpid_q    <= (count_q != '0) ? root_q.pid : 16'd0;
			out_rburst_q  <= (count_q != '0) ? root_q.burst : 16'd0;
			out_since_q   <= (count_q != '0) ? start_q : 32'd0;
			out_total_q   <= count_q;
			out_removed_q <= removed_q;
		end
	end

	assign status            = out_status_q;
	assign dispatched        = out_disp_q;
	assign running_valid     = out_rvalid_q;
	assign running_pid       = out_rpid_q;
	assign running_remaining = out_rburst_q;
	assign running_since     = out_since_q;
	assign entry_total       = out_total_q;
	assign removed_pid       = out_removed_q.pid;
	assign removed_burst     = out_removed_q.burst;
	assign removed_priority  = out_removed_q.prio;

endmodule

// ===== src/prh_checker.sv =====
// Port-level checker for the preemptive priority ready heap, with its bind.
module prh_checker #(
	parameter int unsigned HEAP_DEPTH = prh_pkg::HeapDepthDefault,
	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1)
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          operation,
	input logic [31:0]   current_time,
	input logic [15:0]   process_id,
	input logic [15:0]   burst_time,
	input logic [7:0]    priority_level,
	input logic          out_valid,
	input logic          out_stall,
	input logic [1:0]    status,
	input logic          dispatched,
	input logic          running_valid,
	input logic [15:0]   running_pid,
	input logic [15:0]   running_remaining,
	input logic [31:0]   running_since,
	input logic [CW-1:0] entry_total,
	input logic [15:0]   removed_pid,
	input logic [15:0]   removed_burst,
	input logic [7:0]    removed_priority
);

	// A stalled result stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_total)
		&& $stable(running_pid) && $stable(removed_pid))
		else $error("stalled result changed");

	// The root is occupied exactly when the heap holds entries.
	a_root_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (running_valid == (entry_total != '0)))
		else $error("running_valid disagrees with entry_total");

	// A rejected transaction never dispatches.
	a_reject_nodisp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != prh_pkg::STATUS_OK) |-> !dispatched)
		else $error("dispatch on rejected transaction");

	// A remove on an empty heap reports an empty heap and nothing popped.
	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == prh_pkg::STATUS_EMPTY) |-> (entry_total == '0)
		&& (removed_pid == 16'd0) && (removed_burst == 16'd0) && (removed_priority == 8'd0))
		else $error("empty remove reported contents");

	// The count never exceeds the heap depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_total <= CW'(HEAP_DEPTH)))
		else $error("entry_total above heap depth");

endmodule

bind preemptive_priority_ready_heap prh_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_prh_checker (.*);
